### rtl/rcva_pkg.sv
`default_nettype none

package rcva_pkg;

    // Fixed field widths
    localparam int PITCH_W = 7;
    localparam int ROLE_W  = 4;
    localparam int CAP_W   = 5;
    localparam int MASK_W  = 16;
    localparam int AGE_W   = 64;
    localparam int VOUT_W  = 4;
    // Voice index width inside the cell chain; it can number up to 64 voices
    localparam int IDX_W   = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_CAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SHOT_MASK = 2'd2;

    typedef enum logic [1:0] {
        CMD_NOTE_ON    = 2'd0,
        CMD_NOTE_OFF   = 2'd1,
        CMD_VOICE_DONE = 2'd2,
        CMD_PANIC      = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_NOTE_OFF,
        OP_DONE,
        OP_PANIC
    } t_cell_op;

    typedef struct packed {
        t_command             command;
        logic [PITCH_W-1:0]   pitch;
        logic [3:0]           done_voice;
    } t_in_word;

    typedef struct packed {
        logic [VOUT_W-1:0]    voice_index;
        logic                 stolen;
        logic [MASK_W-1:0]    released_mask;
        logic [MASK_W-1:0]    cleared_mask;
    } t_out_word;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_cell_op             op;
        logic [IDX_W-1:0]     idx;
        logic [PITCH_W-1:0]   pitch;
        logic [ROLE_W-1:0]    role;
        logic                 one_shot;
        logic [AGE_W-1:0]     age;
    } t_cell_cmd;

    // Running scan record handed from cell to cell
    typedef struct packed {
        logic [CAP_W-1:0]     used;
        logic                 role_hit;
        logic [AGE_W-1:0]     role_age;
        logic [IDX_W-1:0]     role_idx;
        logic                 free_hit;
        logic [IDX_W-1:0]     free_idx;
        logic [AGE_W-1:0]     old_age;
        logic [IDX_W-1:0]     old_idx;
    } t_scan;

    localparam t_scan SCAN_INIT = '{
        used:     '0,
        role_hit: 1'b0,
        role_age: '1,
        role_idx: '0,
        free_hit: 1'b0,
        free_idx: '0,
        old_age:  '1,
        old_idx:  '0
    };

endpackage

`default_nettype wire

### rtl/rcva_cell.sv
`default_nettype none

module rcva_cell
    import rcva_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_scan_valid,
    input  wire t_scan     i_scan,
    output logic           o_scan_valid,
    output t_scan          o_scan,
    output logic           o_released,
    output logic           o_cleared
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic               r_active;
    logic               r_releasing;
    logic               r_one_shot;
    logic [PITCH_W-1:0] r_pitch;
    logic [ROLE_W-1:0]  r_role;
    logic [AGE_W-1:0]   r_age;

    logic               r_scan_valid;
    t_scan              r_scan;
    t_scan              n_scan;

    logic               w_hit_idx;
    logic               w_hit_pitch;

    assign w_hit_idx   = (i_cmd.idx == MY_IDX);
    assign w_hit_pitch = r_active && (r_pitch == i_cmd.pitch);

    // Report what this word does to the voice
    always_comb begin
        o_released = 1'b0;
        o_cleared  = 1'b0;
        case (i_cmd.op)
            OP_NOTE_OFF: begin
                o_released = w_hit_pitch && !r_one_shot;
                o_cleared  = w_hit_pitch && r_one_shot;
            end
            OP_DONE:  o_cleared = r_active && w_hit_idx;
            OP_PANIC: o_cleared = r_active;
            default: begin
                o_released = 1'b0;
                o_cleared  = 1'b0;
            end
        endcase
    end

    // Fold this voice into the scan record
    always_comb begin
        n_scan = i_scan;
        if (!r_active) begin
            if (!i_scan.free_hit) begin
                n_scan.free_hit = 1'b1;
                n_scan.free_idx = MY_IDX;
            end
        end else if (r_role == i_cmd.role) begin
            if (i_scan.used != '1) begin
                n_scan.used = i_scan.used + CAP_W'(1);
            end
            if (r_age < i_scan.role_age) begin
                n_scan.role_hit = 1'b1;
                n_scan.role_age = r_age;
                n_scan.role_idx = MY_IDX;
            end
        end
        if (r_age < i_scan.old_age) begin
            n_scan.old_age = r_age;
            n_scan.old_idx = MY_IDX;
        end
    end

    // Voice flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_releasing  <= 1'b0;
            r_scan_valid <= 1'b0;
        end else begin
            r_scan_valid <= i_scan_valid;
            case (i_cmd.op)
                OP_WRITE: begin
                    if (w_hit_idx) begin
                        r_active    <= 1'b1;
                        r_releasing <= 1'b0;
                    end
                end
                OP_NOTE_OFF: begin
                    if (w_hit_pitch) begin
                        if (r_one_shot) begin
                            r_active    <= 1'b0;
                            r_releasing <= 1'b0;
                        end else begin
                            r_releasing <= 1'b1;
                        end
                    end
                end
                OP_DONE: begin
                    if (w_hit_idx) begin
                        r_active    <= 1'b0;
                        r_releasing <= 1'b0;
                    end
                end
                OP_PANIC: begin
                    r_active    <= 1'b0;
                    r_releasing <= 1'b0;
                end
                default: begin
                    r_active    <= r_active;
                    r_releasing <= r_releasing;
                end
            endcase
        end
    end

    // Voice payload and scan record; scan record holds between scans
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE && w_hit_idx) begin
            r_pitch    <= i_cmd.pitch;
            r_role     <= i_cmd.role;
            r_one_shot <= i_cmd.one_shot;
            r_age      <= i_cmd.age;
        end
        if (i_scan_valid) begin
            r_scan <= n_scan;
        end
    end

    assign o_scan_valid = r_scan_valid;
    assign o_scan       = r_scan;

endmodule

`default_nettype wire

### rtl/role_capped_voice_allocator.sv
`default_nettype none

// Role-capped voice allocator.
// Input channel: i_valid / o_stall with an i_data word (command, pitch, done_voice).
// Output channel: o_valid / i_stall with an o_data word (voice_index, stolen,
// released_mask, cleared_mask); exactly one result word per input word.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 active role, 1 voice cap, 2 one-shot role mask); write only while idle.
// Each voice lives in one cell of a chain. A note on sends a scan record down the
// chain, one cell per cycle, through a register in each cell before the voice
// is picked. Note off, voice done and panic act on all cells at once.
// One word is in flight at a time; o_stall is high while it is.
// A finished result sits in the output register while the next word is
// accepted; it holds until the receiver drops i_stall, and the block then
// waits to write back a second result until the first one is taken.
// Reset (synchronous, active low) frees every voice, zeroes the age counter,
// and sets active role 0, voice cap 8 and one-shot mask 0.
// Cell indexes can number up to 64 voices, but voice_index, done_voice and the masks cover voices 0 to 15 only.
module role_capped_voice_allocator
    import rcva_pkg::*;
#(
    parameter int MAX_VOICES = 16,
    parameter int NUM_ROLES  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_word             i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_word                 o_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [MASK_W-1:0]    i_cfg_data
);

    localparam int VEC_W = (MAX_VOICES > MASK_W) ? MAX_VOICES : MASK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    t_state             r_state;
    logic [ROLE_W-1:0]  r_active_role;
    logic [CAP_W-1:0]   r_voice_cap;
    logic [MASK_W-1:0]  r_one_shot_mask;
    logic [AGE_W-1:0]   r_age;
    logic [AGE_W-1:0]   n_age;

    t_command           r_cmd;
    logic [PITCH_W-1:0] r_pitch;
    logic [3:0]         r_done;
    logic [ROLE_W-1:0]  r_role;
    logic               r_launch;

    logic               r_out_valid;
    t_out_word          r_out;

    logic [ROLE_W-1:0]  w_role;
    logic [CAP_W-1:0]   w_cap;
    logic               w_accept;
    logic               w_commit;
    t_cell_cmd          w_cmd;
    t_scan              w_last;
    logic [IDX_W-1:0]   w_pick;
    logic               w_stolen;

    logic [MAX_VOICES:0] w_sv;
    t_scan               w_scan [MAX_VOICES+1];
    logic [VEC_W-1:0]    w_rel;
    logic [VEC_W-1:0]    w_clr;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_commit = (r_state == ST_EXEC) && (!r_out_valid || !i_stall);
    assign n_age    = r_age + AGE_W'(1);

    // Saturate the role to the table and treat a zero cap as one
    always_comb begin
        if (32'(r_active_role) >= NUM_ROLES) begin
            w_role = ROLE_W'(NUM_ROLES - 1);
        end else begin
            w_role = r_active_role;
        end
        w_cap = (r_voice_cap == '0) ? CAP_W'(1) : r_voice_cap;
    end

    // Pick the voice from the finished scan record
    assign w_last = w_scan[MAX_VOICES];
    always_comb begin
        if (w_last.used >= w_cap && w_last.role_hit) begin
            w_pick   = w_last.role_idx;
            w_stolen = 1'b1;
        end else if (w_last.free_hit) begin
            w_pick   = w_last.free_idx;
            w_stolen = 1'b0;
        end else begin
            w_pick   = w_last.old_idx;
            w_stolen = 1'b1;
        end
    end

    // Broadcast word to the cells
    always_comb begin
        w_cmd.op       = OP_NONE;
        w_cmd.idx      = IDX_W'(r_done);
        w_cmd.pitch    = r_pitch;
        w_cmd.role     = r_role;
        w_cmd.one_shot = r_one_shot_mask[r_role];
        w_cmd.age      = n_age;
        if (w_commit) begin
            unique case (r_cmd)
                CMD_NOTE_ON: begin
                    w_cmd.op  = OP_WRITE;
                    w_cmd.idx = w_pick;
                end
                CMD_NOTE_OFF:   w_cmd.op = OP_NOTE_OFF;
                CMD_VOICE_DONE: w_cmd.op = OP_DONE;
                CMD_PANIC:      w_cmd.op = OP_PANIC;
                default:        w_cmd.op = OP_NONE;
            endcase
        end
    end

    // Chain of voice cells
    assign w_sv[0]   = r_launch;
    assign w_scan[0] = SCAN_INIT;

    for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
        rcva_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_scan_valid (w_sv[g]),
            .i_scan       (w_scan[g]),
            .o_scan_valid (w_sv[g+1]),
            .o_scan       (w_scan[g+1]),
            .o_released   (w_rel[g]),
            .o_cleared    (w_clr[g])
        );
    end

    for (genvar g = MAX_VOICES; g < VEC_W; g++) begin : g_pad
        assign w_rel[g] = 1'b0;
        assign w_clr[g] = 1'b0;
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_active_role   <= '0;
            r_voice_cap     <= CAP_W'(8);
            r_one_shot_mask <= '0;
            r_age           <= '0;
            r_launch        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_launch <= w_accept && (i_data.command == CMD_NOTE_ON);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_ROLE:   r_active_role   <= i_cfg_data[ROLE_W-1:0];
                    CFG_VOICE_CAP:     r_voice_cap     <= i_cfg_data[CAP_W-1:0];
                    CFG_ONE_SHOT_MASK: r_one_shot_mask <= i_cfg_data;
                    default:           r_voice_cap     <= r_voice_cap;
                endcase
            end
            // Load a new result, else drop the taken one
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_data.command == CMD_NOTE_ON) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_sv[MAX_VOICES]) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                        if (r_cmd == CMD_NOTE_ON) begin
                            r_age <= n_age;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Latch the input word and the result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_data.command;
            r_pitch <= i_data.pitch;
            r_done  <= i_data.done_voice;
            r_role  <= w_role;
        end
        if (w_commit) begin
            r_out.voice_index   <= (r_cmd == CMD_NOTE_ON) ? w_pick[VOUT_W-1:0] : '0;
            r_out.stolen        <= (r_cmd == CMD_NOTE_ON) && w_stolen;
            r_out.released_mask <= w_rel[MASK_W-1:0];
            r_out.cleared_mask  <= w_clr[MASK_W-1:0];
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
